[rtl/c8_pkg.sv]
// shared types, constants and font table for the chip8 instruction core
package c8_pkg;

    localparam int MEM_BYTES_DEF     = 4096;
    localparam int FONT_BASE_DEF     = 80;
    localparam int PROGRAM_BASE_DEF  = 512;
    localparam int STACK_BASE_DEF    = 3744;
    localparam int SCREEN_WIDTH_DEF  = 64;
    localparam int SCREEN_HEIGHT_DEF = 32;

    localparam int ADDR_W  = 12;
    localparam int SCR_W   = 8;
    localparam int GLYPH_N = 80;

    localparam logic [2:0] ACT_EXEC  = 3'd0;
    localparam logic [2:0] ACT_WRITE = 3'd1;
    localparam logic [2:0] ACT_KEY   = 3'd2;
    localparam logic [2:0] ACT_READ  = 3'd3;
    localparam logic [2:0] ACT_SCR   = 3'd4;

    localparam logic [1:0] ST_EXEC    = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_WAIT    = 2'd2;
    localparam logic [1:0] ST_ACCESS  = 2'd3;

    localparam logic [1:0] REG_QUIRK = 2'd0;

    typedef struct packed {
        logic [2:0]  action;
        logic [11:0] address;
        logic [7:0]  write_data;
        logic [3:0]  key_index;
        logic        key_down;
        logic [7:0]  random_byte;
    } c8_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] instruction;
        logic [11:0] program_counter;
        logic [7:0]  read_data;
        logic        sound_on;
        logic [7:0]  delay_value;
    } c8_out_t;

    function automatic logic [7:0] glyph(input logic [6:0] k);
        logic [7:0] g;
        begin
            unique case (k)
                7'd0: g = 8'hF0; 7'd1: g = 8'h90; 7'd2: g = 8'h90; 7'd3: g = 8'h90;
                7'd4: g = 8'hF0; 7'd5: g = 8'h20; 7'd6: g = 8'h60; 7'd7: g = 8'h20;
                7'd8: g = 8'h20; 7'd9: g = 8'h70; 7'd10: g = 8'hF0; 7'd11: g = 8'h10;
                7'd12: g = 8'hF0; 7'd13: g = 8'h80; 7'd14: g = 8'hF0; 7'd15: g = 8'hF0;
                7'd16: g = 8'h10; 7'd17: g = 8'hF0; 7'd18: g = 8'h10; 7'd19: g = 8'hF0;
                7'd20: g = 8'h90; 7'd21: g = 8'h90; 7'd22: g = 8'hF0; 7'd23: g = 8'h10;
                7'd24: g = 8'h10; 7'd25: g = 8'hF0; 7'd26: g = 8'h80; 7'd27: g = 8'hF0;
                7'd28: g = 8'h10; 7'd29: g = 8'hF0; 7'd30: g = 8'hF0; 7'd31: g = 8'h80;
                7'd32: g = 8'hF0; 7'd33: g = 8'h90; 7'd34: g = 8'hF0; 7'd35: g = 8'hF0;
                7'd36: g = 8'h10; 7'd37: g = 8'h20; 7'd38: g = 8'h40; 7'd39: g = 8'h40;
                7'd40: g = 8'hF0; 7'd41: g = 8'h90; 7'd42: g = 8'hF0; 7'd43: g = 8'h90;
                7'd44: g = 8'hF0; 7'd45: g = 8'hF0; 7'd46: g = 8'h90; 7'd47: g = 8'hF0;
                7'd48: g = 8'h10; 7'd49: g = 8'hF0; 7'd50: g = 8'hF0; 7'd51: g = 8'h90;
                7'd52: g = 8'hF0; 7'd53: g = 8'h90; 7'd54: g = 8'h90; 7'd55: g = 8'hE0;
                7'd56: g = 8'h90; 7'd57: g = 8'hE0; 7'd58: g = 8'h90; 7'd59: g = 8'hE0;
                7'd60: g = 8'hF0; 7'd61: g = 8'h80; 7'd62: g = 8'h80; 7'd63: g = 8'h80;
                7'd64: g = 8'hF0; 7'd65: g = 8'hE0; 7'd66: g = 8'h90; 7'd67: g = 8'h90;
                7'd68: g = 8'h90; 7'd69: g = 8'hE0; 7'd70: g = 8'hF0; 7'd71: g = 8'h80;
                7'd72: g = 8'hF0; 7'd73: g = 8'h80; 7'd74: g = 8'hF0; 7'd75: g = 8'hF0;
                7'd76: g = 8'h80; 7'd77: g = 8'hF0; 7'd78: g = 8'h80; 7'd79: g = 8'h80;
                default: g = 8'h00;
            endcase
            return g;
        end
    endfunction

endpackage

[rtl/c8_stream_if.sv]
// valid/ready channel interface carrying one payload
interface c8_stream_if #(parameter type payload_t = logic [7:0]);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/c8_ram.sv]
// generic single-port ram with registered read
module c8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

[rtl/chip8_instruction_core.sv]
// chip8 instruction core: one action per transaction, sequenced over memory
//
// channels: in_ch (sink) takes one action transaction; out_ch (source) gives one
// result transaction for each accepted action. configuration goes through an apb
// write port; register 0 is quirk_mode at byte address 0.
// after reset a clearing pass over all 4096 bytes loads font glyphs into
// main memory and zeroes the rest, and the 256-byte screen, before in_ch.ready
// rises. an execute fetches both opcode bytes and then executes; a call pushes
// the return address as two bytes and a return pops them, a register load reads
// and a store writes one byte per register, a draw reads each sprite row and
// rewrites one or two screen bytes for it, and a screen clear writes every
// screen byte. all memory traffic goes through the one main memory port and
// one screen port, sequenced by the state machine.
// one action is in flight at a time; the result sits in an output register
// until taken, and a stalled receiver holds in_ch.ready low with the result pending.
// reset is asynchronous, active low, and restarts the clearing pass.
module chip8_instruction_core
    import c8_pkg::*;
#(
    parameter int FONT_BASE    = FONT_BASE_DEF,
    parameter int PROGRAM_BASE = PROGRAM_BASE_DEF,
    parameter int STACK_BASE   = STACK_BASE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    c8_stream_if.sink   in_ch,
    c8_stream_if.source out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam logic [4:0] S_INIT   = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_ACC    = 5'd2;
    localparam logic [4:0] S_F1     = 5'd3;
    localparam logic [4:0] S_F2     = 5'd4;
    localparam logic [4:0] S_F3     = 5'd5;
    localparam logic [4:0] S_EXEC   = 5'd6;
    localparam logic [4:0] S_CLS    = 5'd7;
    localparam logic [4:0] S_RET1   = 5'd8;
    localparam logic [4:0] S_RET2   = 5'd9;
    localparam logic [4:0] S_RET3   = 5'd10;
    localparam logic [4:0] S_CALL   = 5'd11;
    localparam logic [4:0] S_BCD    = 5'd12;
    localparam logic [4:0] S_STORE  = 5'd13;
    localparam logic [4:0] S_LOAD1  = 5'd14;
    localparam logic [4:0] S_LOAD2  = 5'd15;
    localparam logic [4:0] S_DROW   = 5'd16;
    localparam logic [4:0] S_DRD    = 5'd17;
    localparam logic [4:0] S_DB0    = 5'd18;
    localparam logic [4:0] S_DB0W   = 5'd19;
    localparam logic [4:0] S_DB1    = 5'd20;
    localparam logic [4:0] S_DB1W   = 5'd21;
    localparam logic [4:0] S_OUT    = 5'd22;

    localparam logic [11:0] FONT_A  = ADDR_W'(FONT_BASE);
    localparam logic [11:0] GLYPH_E = ADDR_W'(FONT_BASE + GLYPH_N);

    logic [4:0]  state_reg, state_next;
    logic [12:0] cnt_reg, cnt_next;
    logic [7:0]  v_reg [16];
    logic [7:0]  v_next [16];
    logic [15:0] i_reg, i_next;
    logic [11:0] pc_reg, pc_next;
    logic [11:0] sp_reg, sp_next;
    logic [7:0]  dt_reg, dt_next;
    logic [7:0]  st_reg, st_next;
    logic [15:0] keys_reg, keys_next;
    logic [4:0]  lk_reg, lk_next;
    logic        quirk_reg, quirk_next;
    c8_in_t      req_reg, req_next;
    logic [15:0] op_reg, op_next;
    logic [7:0]  tmp_reg, tmp_next;
    logic [7:0]  row_reg, row_next;
    logic [5:0]  dx_reg, dx_next;
    logic [4:0]  dy_reg, dy_next;
    logic        ovalid_reg, ovalid_next;
    c8_out_t     res_reg, res_next;

    logic        mwe;
    logic [11:0] maddr;
    logic [7:0]  mwdata, mrdata;
    logic        swe;
    logic [7:0]  saddr, swdata, srdata;

    c8_ram #(.WIDTH(8), .DEPTH(4096)) u_mem (
        .clk(clk), .we(mwe), .addr(maddr), .wdata(mwdata), .rdata(mrdata));
    c8_ram #(.WIDTH(8), .DEPTH(256)) u_scr (
        .clk(clk), .we(swe), .addr(saddr), .wdata(swdata), .rdata(srdata));

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr == REG_QUIRK) ? {31'd0, quirk_reg} : 32'd0;

    assign in_ch.ready     = (state_reg == S_IDLE) && !ovalid_reg;
    assign out_ch.valid    = ovalid_reg;
    assign out_ch.payload  = res_reg;

    logic [3:0]  ox, oy, on;
    logic [7:0]  onn, vx, vy;
    logic [11:0] onnn;
    logic [8:0]  sum9;
    logic [7:0]  shsrc;
    logic [5:0]  x0;
    logic [4:0]  y0;
    logic [4:0]  drow_y;
    logic [15:0] row_sh;
    logic [7:0]  dmask;

    always_comb
    begin
        ox   = op_reg[11:8];
        oy   = op_reg[7:4];
        on   = op_reg[3:0];
        onn  = op_reg[7:0];
        onnn = op_reg[11:0];
        vx   = v_reg[ox];
        vy   = v_reg[oy];
        sum9 = {1'b0, vx} + {1'b0, vy};
        shsrc = quirk_reg ? vx : vy;
        x0   = dx_reg;
        y0   = dy_reg;
        drow_y = y0 + cnt_reg[4:0];
        row_sh = {row_reg, 8'd0} >> x0[2:0];
        dmask  = cnt_reg[12] ? row_sh[7:0] : row_sh[15:8];
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        v_next      = v_reg;
        i_next      = i_reg;
        pc_next     = pc_reg;
        sp_next     = sp_reg;
        dt_next     = dt_reg;
        st_next     = st_reg;
        keys_next   = keys_reg;
        lk_next     = lk_reg;
        quirk_next  = quirk_reg;
        req_next    = req_reg;
        op_next     = op_reg;
        tmp_next    = tmp_reg;
        row_next    = row_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        ovalid_next = ovalid_reg;
        res_next    = res_reg;
        mwe = 1'b0; maddr = req_reg.address; mwdata = req_reg.write_data;
        swe = 1'b0; saddr = req_reg.address[7:0]; swdata = 8'd0;

        if (cfg_wr && paddr == REG_QUIRK)
        begin
            quirk_next = pwdata[0];
        end
        if (ovalid_reg && out_ch.ready)
        begin
            ovalid_next = 1'b0;
        end

        res_next.sound_on    = (st_reg != 8'd0);
        res_next.delay_value = dt_reg;

        unique case (state_reg)
            S_INIT:
            begin
                maddr  = cnt_reg[11:0];
                mwe    = 1'b1;
                mwdata = (cnt_reg[11:0] >= FONT_A && cnt_reg[11:0] < GLYPH_E) ?
                         glyph(7'(cnt_reg[11:0] - FONT_A)) : 8'd0;
                swe    = 1'b1;
                saddr  = cnt_reg[7:0];
                cnt_next = cnt_reg + 13'd1;
                if (cnt_reg[11:0] == 12'hFFF)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_ch.valid && !ovalid_reg)
                begin
                    req_next   = in_ch.payload;
                    state_next = (in_ch.payload.action == ACT_EXEC) ? S_F1 : S_ACC;
                    cnt_next   = 13'd0;
                end
            end
            S_ACC:
            begin
                res_next.status      = ST_ACCESS;
                res_next.instruction = 16'd0;
                res_next.read_data   = 8'd0;
                if (req_reg.action == ACT_WRITE)
                begin
                    mwe = 1'b1;
                end
                if (req_reg.action == ACT_KEY)
                begin
                    keys_next[req_reg.key_index] = req_reg.key_down;
                    if (req_reg.key_down)
                    begin
                        lk_next = {1'b0, req_reg.key_index};
                    end
                end
                if (cnt_reg[0])
                begin
                    if (req_reg.action == ACT_READ) res_next.read_data = mrdata;
                    if (req_reg.action == ACT_SCR)  res_next.read_data = srdata;
                    state_next = S_OUT;
                end
                cnt_next = 13'd1;
            end
            S_F1:
            begin
                maddr = pc_reg;
                state_next = S_F2;
            end
            S_F2:
            begin
                maddr = pc_reg + 12'd1;
                op_next[15:8] = mrdata;
                state_next = S_F3;
            end
            S_F3:
            begin
                op_next[7:0] = mrdata;
                pc_next = pc_reg + 12'd2;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                res_next.status      = ST_EXEC;
                res_next.instruction = op_reg;
                res_next.read_data   = 8'd0;
                state_next = S_OUT;
                cnt_next = 13'd0;
                unique case (op_reg[15:12])
                    4'h0:
                    begin
                        if (onn == 8'hE0) state_next = S_CLS;
                        else if (onn == 8'hEE) state_next = S_RET1;
                        else res_next.status = ST_UNKNOWN;
                    end
                    4'h1: pc_next = onnn;
                    4'h2: state_next = S_CALL;
                    4'h3: if (vx == onn) pc_next = pc_reg + 12'd2;
                    4'h4: if (vx != onn) pc_next = pc_reg + 12'd2;
                    4'h5: if (vx == vy) pc_next = pc_reg + 12'd2;
                    4'h6: v_next[ox] = onn;
                    4'h7: v_next[ox] = vx + onn;
                    4'h8:
                    begin
                        unique case (on)
                            4'h0: v_next[ox] = vy;
                            4'h1: v_next[ox] = vx | vy;
                            4'h2: v_next[ox] = vx & vy;
                            4'h3: v_next[ox] = vx ^ vy;
                            4'h4:
                            begin
                                v_next[15] = {7'd0, sum9[8]};
                                v_next[ox] = sum9[7:0];
                            end
                            4'h5:
                            begin
                                v_next[15] = {7'd0, vx > vy};
                                v_next[ox] = vx - vy;
                            end
                            4'h6:
                            begin
                                v_next[15] = {7'd0, shsrc[0]};
                                v_next[ox] = shsrc >> 1;
                            end
                            4'h7:
                            begin
                                v_next[15] = {7'd0, vy > vx};
                                v_next[ox] = vy - vx;
                            end
                            4'hE:
                            begin
                                v_next[15] = {7'd0, shsrc[7]};
                                v_next[ox] = shsrc << 1;
                            end
                            default: res_next.status = ST_UNKNOWN;
                        endcase
                    end
                    4'h9: if (vx != vy) pc_next = pc_reg + 12'd2;
                    4'hA: i_next = {4'd0, onnn};
                    4'hB: pc_next = onnn + {4'd0, v_reg[0]};
                    4'hC: v_next[ox] = req_reg.random_byte & onn;
                    4'hD:
                    begin
                        dx_next = vx[5:0];
                        dy_next = vy[4:0];
                        v_next[15] = 8'd0;
                        state_next = S_DROW;
                    end
                    4'hE:
                    begin
                        if (onn == 8'h9E)
                        begin
                            if (keys_reg[vx[3:0]]) pc_next = pc_reg + 12'd2;
                        end
                        else if (onn == 8'hA1)
                        begin
                            if (!keys_reg[vx[3:0]]) pc_next = pc_reg + 12'd2;
                        end
                        else res_next.status = ST_UNKNOWN;
                    end
                    default:
                    begin
                        unique case (onn)
                            8'h07: v_next[ox] = dt_reg;
                            8'h0A:
                            begin
                                if (lk_reg[4])
                                begin
                                    pc_next = pc_reg - 12'd2;
                                    res_next.status = ST_WAIT;
                                end
                                else v_next[ox] = {4'd0, lk_reg[3:0]};
                            end
                            8'h15: dt_next = vx;
                            8'h18: st_next = vx;
                            8'h1E: i_next = i_reg + {8'd0, vx};
                            8'h29: i_next = 16'(FONT_BASE) + {6'd0, vx, 2'b00} + {8'd0, vx};
                            8'h33:
                            begin
                                tmp_next = vx;
                                state_next = S_BCD;
                            end
                            8'h55: state_next = S_STORE;
                            8'h65: state_next = S_LOAD1;
                            default: res_next.status = ST_UNKNOWN;
                        endcase
                    end
                endcase
            end
            S_CLS:
            begin
                swe = 1'b1;
                saddr = cnt_reg[7:0];
                cnt_next = cnt_reg + 13'd1;
                if (cnt_reg[7:0] == 8'hFF) state_next = S_OUT;
            end
            S_RET1:
            begin
                maddr = sp_reg - 12'd1;
                state_next = S_RET2;
            end
            S_RET2:
            begin
                maddr = sp_reg - 12'd2;
                tmp_next = mrdata;
                state_next = S_RET3;
            end
            S_RET3:
            begin
                pc_next = {mrdata[3:0], tmp_reg};
                sp_next = sp_reg - 12'd2;
                state_next = S_OUT;
            end
            S_CALL:
            begin
                mwe = 1'b1;
                maddr = sp_reg;
                mwdata = cnt_reg[0] ? pc_reg[7:0] : {4'd0, pc_reg[11:8]};
                sp_next = sp_reg + 12'd1;
                cnt_next = cnt_reg + 13'd1;
                if (cnt_reg[0])
                begin
                    pc_next = onnn;
                    state_next = S_OUT;
                end
            end
            S_BCD:
            begin
                mwe = 1'b1;
                maddr = i_reg[11:0] + cnt_reg[11:0];
                cnt_next = cnt_reg + 13'd1;
                unique case (cnt_reg[1:0])
                    2'd0:
                    begin
                        if (tmp_reg >= 8'd200) mwdata = 8'd2;
                        else if (tmp_reg >= 8'd100) mwdata = 8'd1;
                        else mwdata = 8'd0;
                        tmp_next = (tmp_reg >= 8'd200) ? tmp_reg - 8'd200 :
                                   (tmp_reg >= 8'd100) ? tmp_reg - 8'd100 : tmp_reg;
                    end
                    2'd1:
                    begin
                        mwdata = 8'(({8'd0, tmp_reg} * 16'd205) >> 11);
                        tmp_next = tmp_reg - 8'(mwdata * 8'd10);
                    end
                    default:
                    begin
                        mwdata = tmp_reg;
                        state_next = S_OUT;
                    end
                endcase
            end
            S_STORE:
            begin
                mwe = 1'b1;
                maddr = i_reg[11:0] + cnt_reg[11:0];
                mwdata = v_reg[cnt_reg[3:0]];
                cnt_next = cnt_reg + 13'd1;
                if (cnt_reg[3:0] == ox)
                begin
                    if (!quirk_reg) i_next = i_reg + {12'd0, ox} + 16'd1;
                    state_next = S_OUT;
                end
            end
            S_LOAD1:
            begin
                maddr = i_reg[11:0] + cnt_reg[11:0];
                state_next = S_LOAD2;
            end
            S_LOAD2:
            begin
                v_next[cnt_reg[3:0]] = mrdata;
                cnt_next = cnt_reg + 13'd1;
                if (cnt_reg[3:0] == ox)
                begin
                    if (!quirk_reg) i_next = i_reg + {12'd0, ox} + 16'd1;
                    state_next = S_OUT;
                end
                else state_next = S_LOAD1;
            end
            S_DROW:
            begin
                if (cnt_reg[4:0] >= 5'(on) || ({1'b0, y0} + {1'b0, cnt_reg[4:0]}) > 6'd31)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    maddr = i_reg[11:0] + {7'd0, cnt_reg[4:0]};
                    state_next = S_DRD;
                end
            end
            S_DRD:
            begin
                row_next = mrdata;
                cnt_next[12] = 1'b0;
                state_next = S_DB0;
            end
            S_DB0, S_DB1:
            begin
                saddr = {drow_y, cnt_reg[12] ? x0[5:3] + 3'd1 : x0[5:3]};
                state_next = (state_reg == S_DB0) ? S_DB0W : S_DB1W;
            end
            default:
            begin
                if (state_reg == S_DB0W || state_reg == S_DB1W)
                begin
                    saddr = {drow_y, cnt_reg[12] ? x0[5:3] + 3'd1 : x0[5:3]};
                    swe = 1'b1;
                    swdata = srdata ^ dmask;
                    if ((srdata & dmask) != 8'd0) v_next[15] = 8'd1;
                    if (state_reg == S_DB0W && x0[5:3] != 3'd7 && x0[2:0] != 3'd0)
                    begin
                        cnt_next[12] = 1'b1;
                        state_next = S_DB1;
                    end
                    else
                    begin
                        cnt_next = {1'b0, cnt_reg[11:0] + 12'd1};
                        state_next = S_DROW;
                    end
                end
                else
                begin
                    res_next.program_counter = pc_reg;
                    if (!ovalid_reg || out_ch.ready)
                    begin
                        ovalid_next = 1'b1;
                        state_next = S_IDLE;
                    end
                    res_next = res_reg;
                    res_next.program_counter = pc_reg;
                    res_next.sound_on = (st_reg != 8'd0);
                    res_next.delay_value = dt_reg;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            cnt_reg    <= 13'd0;
            for (int k = 0; k < 16; k++) v_reg[k] <= 8'd0;
            i_reg      <= 16'd0;
            pc_reg     <= ADDR_W'(PROGRAM_BASE);
            sp_reg     <= ADDR_W'(STACK_BASE);
            dt_reg     <= 8'd0;
            st_reg     <= 8'd0;
            keys_reg   <= 16'd0;
            lk_reg     <= 5'd16;
            quirk_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            v_reg      <= v_next;
            i_reg      <= i_next;
            pc_reg     <= pc_next;
            sp_reg     <= sp_next;
            dt_reg     <= dt_next;
            st_reg     <= st_next;
            keys_reg   <= keys_next;
            lk_reg     <= lk_next;
            quirk_reg  <= quirk_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        op_reg  <= op_next;
        tmp_reg <= tmp_next;
        row_reg <= row_next;
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        res_reg <= res_next;
    end

`ifndef SYNTH
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> state_reg == S_IDLE) else $error("ready outside idle");
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(res_reg))
        else $error("result dropped under stall");
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> !in_ch.ready) else $error("second transaction taken");
    a_last_key: assert property (@(posedge clk) disable iff (!rst_n)
        lk_reg <= 5'd16) else $error("last key out of range");
`endif
endmodule
